// ===== design/double_ended_queue_store_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue store
// Shared concurrent assertion forms with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_STORE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_STORE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DEQS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DEQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/deqs_pkg.sv =====
// ----------------------------------------------------------------------------
// deqs_pkg
// Types and fixed field widths shared by the double-ended queue store.
// ----------------------------------------------------------------------------
`default_nettype none

package deqs_pkg;

    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 10;
    localparam int COUNT_W   = 11;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 112;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_READ       = 2'd2,
        CMD_CLEAR      = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
    } t_dp_ctl;

endpackage

`default_nettype wire

// ===== design/deqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// deqs_ctrl
// Handshake controller: accepts a command and holds its result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module deqs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output deqs_pkg::t_dp_ctl      o_ctl
);

    deqs_pkg::t_state r_state;
    deqs_pkg::t_state n_state;
    logic             w_accept;

    // A new transaction may enter in the same cycle the held result leaves.
    assign w_accept = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            deqs_pkg::ST_IDLE: begin
                if (w_accept) n_state = deqs_pkg::ST_RESP;
            end
            deqs_pkg::ST_RESP: begin
                if (w_accept) n_state = deqs_pkg::ST_RESP;
                else if (i_m_tready) n_state = deqs_pkg::ST_IDLE;
            end
            default: n_state = deqs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            deqs_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            deqs_pkg::ST_RESP: begin
                o_s_tready = i_m_tready;
                o_m_tvalid = 1'b1;
            end
            default: begin
                o_s_tready = 1'b0;
                o_m_tvalid = 1'b0;
            end
        endcase
        o_ctl.load = i_s_tvalid && o_s_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deqs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/deqs_datapath.sv =====
// ----------------------------------------------------------------------------
// deqs_datapath
// Ring store, front pointer, count, cached end values and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module deqs_datapath #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  deqs_pkg::t_dp_ctl                     i_ctl,
    input  deqs_pkg::t_cmd                        i_command,
    input  wire logic [deqs_pkg::VALUE_W-1:0]     i_value,
    input  wire logic [deqs_pkg::POS_W-1:0]       i_position,
    output logic      [deqs_pkg::VALUE_W-1:0]     o_read_value,
    output logic                                  o_index_error,
    output logic                                  o_overflow,
    output logic      [deqs_pkg::COUNT_W-1:0]     o_count,
    output logic                                  o_is_empty,
    output logic      [deqs_pkg::VALUE_W-1:0]     o_front_value,
    output logic      [deqs_pkg::VALUE_W-1:0]     o_back_value
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW1  = AW + 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > deqs_pkg::POS_W) ? CW : deqs_pkg::POS_W;
    localparam int SW   = ((AW > deqs_pkg::POS_W) ? AW : deqs_pkg::POS_W) + 1;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_q;

    logic [AW-1:0]         r_front;
    logic [AW-1:0]         n_front;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [DATA_WIDTH-1:0] r_front_val;
    logic [DATA_WIDTH-1:0] n_front_val;
    logic [DATA_WIDTH-1:0] r_back_val;
    logic [DATA_WIDTH-1:0] n_back_val;
    logic                  r_rd_ok;
    logic                  n_rd_ok;
    logic                  r_index_error;
    logic                  n_index_error;
    logic                  r_overflow;
    logic                  n_overflow;

    logic [DATA_WIDTH-1:0] w_val;
    logic                  w_full;
    logic                  w_empty;
    logic [AW-1:0]         w_front_dec;
    logic [AW1-1:0]        w_back_sum;
    logic [AW-1:0]         w_back_idx;
    logic                  w_pos_ok;
    logic [SW-1:0]         w_rd_sum;
    logic [AW-1:0]         w_rd_idx;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;

    assign w_val   = DATA_WIDTH'(i_value);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : (r_front - AW'(1));

    // The back slot is front + count; both stay below DEPTH on a push, so one
    // conditional subtract wraps the sum.
    assign w_back_sum = AW1'(r_front) + AW1'(r_count);
    assign w_back_idx = (w_back_sum >= AW1'(DEPTH)) ? AW'(w_back_sum - AW1'(DEPTH))
                                                    : AW'(w_back_sum);

    assign w_pos_ok = (CMPW'(i_position) < CMPW'(r_count));
    assign w_rd_sum = SW'(r_front) + SW'(i_position);
    assign w_rd_idx = (w_rd_sum >= SW'(DEPTH)) ? AW'(w_rd_sum - SW'(DEPTH))
                                               : AW'(w_rd_sum);

    always_comb begin
        n_front       = r_front;
        n_count       = r_count;
        n_front_val   = r_front_val;
        n_back_val    = r_back_val;
        n_rd_ok       = 1'b0;
        n_index_error = 1'b0;
        n_overflow    = 1'b0;
        w_we          = 1'b0;
        w_waddr       = w_back_idx;
        case (i_command)
            deqs_pkg::CMD_PUSH_FRONT: begin
                if (w_full) begin
                    n_overflow = 1'b1;
                end else begin
                    n_front     = w_front_dec;
                    n_count     = r_count + CW'(1);
                    n_front_val = w_val;
                    if (w_empty) n_back_val = w_val;
                    w_we        = 1'b1;
                    w_waddr     = w_front_dec;
                end
            end
            deqs_pkg::CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_overflow = 1'b1;
                end else begin
                    n_count    = r_count + CW'(1);
                    n_back_val = w_val;
                    if (w_empty) n_front_val = w_val;
                    w_we       = 1'b1;
                    w_waddr    = w_back_idx;
                end
            end
            deqs_pkg::CMD_READ: begin
                n_rd_ok       = w_pos_ok;
                n_index_error = !w_pos_ok;
            end
            deqs_pkg::CMD_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
                n_front = r_front;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_ctl.load) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_front_val   <= n_front_val;
            r_back_val    <= n_back_val;
            r_rd_ok       <= n_rd_ok;
            r_index_error <= n_index_error;
            r_overflow    <= n_overflow;
        end
    end

    // A read never writes, so the registered read sees every earlier push.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && w_we) begin
            r_mem[w_waddr] <= w_val;
        end
        if (i_ctl.load && n_rd_ok) begin
            r_mem_q <= r_mem[w_rd_idx];
        end
    end

    assign o_read_value  = r_rd_ok ? deqs_pkg::VALUE_W'(r_mem_q) : '0;
    assign o_index_error = r_index_error;
    assign o_overflow    = r_overflow;
    assign o_count       = deqs_pkg::COUNT_W'(r_count);
    assign o_is_empty    = (r_count == '0);
    assign o_front_value = (r_count == '0) ? '0 : deqs_pkg::VALUE_W'(r_front_val);
    assign o_back_value  = (r_count == '0) ? '0 : deqs_pkg::VALUE_W'(r_back_val);

endmodule

`default_nettype wire

// ===== design/double_ended_queue_store_core.sv =====
// An accepted command's result is registered and appears on the output in the cycle after acceptance.
// Throughput: one command per cycle while results are taken, since the held
// result may leave in the cycle that the next command enters.
// The rate is set by the controller, which holds one result at a time.
// Reset clears the front pointer, the count and the output valid; the store
// itself is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// double_ended_queue_store_core
// Double-ended queue on a ring store: push front, push back, read, clear.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_store_core_macros.svh"

module double_ended_queue_store_core #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // value [31:0], position [41:32], zero [47:42]
    input  wire logic [deqs_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // command [1:0]
    input  wire logic [deqs_pkg::CMD_W-1:0]         i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // read_value [31:0], index_error [32], overflow [33], count [44:34],
    // is_empty [45], front_value [77:46], back_value [109:78], zero [111:110]
    output logic      [deqs_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);

    deqs_pkg::t_dp_ctl                 w_ctl;
    logic [deqs_pkg::VALUE_W-1:0]      w_read_value;
    logic                              w_index_error;
    logic                              w_overflow;
    logic [deqs_pkg::COUNT_W-1:0]      w_count;
    logic                              w_is_empty;
    logic [deqs_pkg::VALUE_W-1:0]      w_front_value;
    logic [deqs_pkg::VALUE_W-1:0]      w_back_value;

    deqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_ctl      (w_ctl)
    );

    deqs_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_command     (deqs_pkg::t_cmd'(i_s_axis_tuser)),
        .i_value       (i_s_axis_tdata[31:0]),
        .i_position    (i_s_axis_tdata[41:32]),
        .o_read_value  (w_read_value),
        .o_index_error (w_index_error),
        .o_overflow    (w_overflow),
        .o_count       (w_count),
        .o_is_empty    (w_is_empty),
        .o_front_value (w_front_value),
        .o_back_value  (w_back_value)
    );

    assign o_m_axis_tdata = {2'b00, w_back_value, w_front_value, w_is_empty, w_count,
                             w_overflow, w_index_error, w_read_value};

    `DEQS_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, o_m_axis_tvalid,
        "accepted command did not produce a result")

    `DEQS_ASSERT_SAME(a_overflow_not_empty, i_clk, i_rst_n,
        o_m_axis_tvalid && w_overflow, !w_is_empty && !w_index_error,
        "overflow reported on an empty deque or with an index error")

    `DEQS_ASSERT_SAME(a_index_error_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && w_index_error, w_read_value == '0,
        "index error with a nonzero read value")

    `DEQS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n,
        o_m_axis_tvalid, (DEPTH >= 2048) || (32'(w_count) <= 32'(DEPTH)),
        "count exceeds the store depth")

endmodule

`default_nettype wire
